[rtl/fwh_pkg.sv]
package fwh_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned WIDTH_W  = 31;
    localparam int unsigned COUNT_W  = 11;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 31'd65536;
    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 32'sh8000_0000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_item;
    } t_req;

endpackage

[rtl/fwh_ram.sv]
module fwh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fwh_div.sv]
module fwh_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);

    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [30:0] r_den;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_diff  = w_trial - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[32]) begin
                    r_rem <= w_diff[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/fwh_front.sv]
module fwh_front #(
    parameter int unsigned MAX_SAMPLES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  fwh_pkg::t_req                    i_req,
    output logic                             o_we,
    output logic [$clog2(MAX_SAMPLES)-1:0]   o_waddr,
    output logic [31:0]                      o_wdata,
    output logic                             o_go,
    output logic [$clog2(MAX_SAMPLES+1)-1:0] o_count,
    output logic signed [31:0]               o_min,
    output logic signed [31:0]               o_max,
    input  logic                             i_clear
);
    import fwh_pkg::*;

    localparam int unsigned CW = $clog2(MAX_SAMPLES+1);

    logic [CW-1:0]        r_count;
    logic signed [31:0]   r_min;
    logic signed [31:0]   r_max;
    logic                 r_go;
    logic                 w_acc;
    logic                 w_room;
    logic signed [31:0]   w_s;

    assign w_acc  = i_start && !i_busy;
    assign w_room = r_count < CW'(MAX_SAMPLES);
    assign w_s    = $signed(i_req.sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= MIN_RESET;
            r_max   <= MAX_RESET;
            r_go    <= 1'b0;
        end else begin
            r_go <= w_acc && i_req.last_item;
            if (i_clear) begin
                r_count <= '0;
                r_min   <= MIN_RESET;
                r_max   <= MAX_RESET;
            end else if (w_acc && w_room) begin
                r_count <= r_count + CW'(1);
                if (w_s < r_min) r_min <= w_s;
                if (w_s > r_max) r_max <= w_s;
            end
        end
    end

    assign o_we    = w_acc && w_room;
    assign o_waddr = r_count[$clog2(MAX_SAMPLES)-1:0];
    assign o_wdata = i_req.sample;
    assign o_go    = r_go;
    assign o_count = r_count;
    assign o_min   = r_min;
    assign o_max   = r_max;

endmodule

[rtl/fwh_back.sv]
module fwh_back #(
    parameter int unsigned MAX_SAMPLES = 1024,
    parameter int unsigned MAX_BUCKETS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic [$clog2(MAX_SAMPLES+1)-1:0] i_count,
    input  logic signed [31:0]               i_min,
    input  logic signed [31:0]               i_max,
    input  logic [30:0]                      i_width,
    output logic [$clog2(MAX_SAMPLES)-1:0]   o_raddr,
    input  logic [31:0]                      i_rdata,
    output logic                             o_busy,
    output logic                             o_clear,
    output logic                             o_valid,
    output logic signed [31:0]               o_bucket_low,
    output logic [10:0]                      o_bucket_count,
    output logic                             o_clipped,
    output logic                             o_last_bucket
);
    import fwh_pkg::*;

    localparam int unsigned CW = $clog2(MAX_SAMPLES+1);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SPAN, S_READ, S_DATA, S_BIN, S_INC, S_ELOAD, S_EMIT, S_CLEAR
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_n;
    logic [31:0]        r_mn;
    logic [31:0]        r_span;
    logic [30:0]        r_w;
    logic [6:0]         r_nb;
    logic               r_clip;
    logic [BW-1:0]      r_b;
    logic [BW-1:0]      r_bin;
    logic [31:0]        r_low;
    logic               r_dstart;
    logic               r_valid;
    logic [10:0]        r_ocount;
    logic               r_olast;
    logic               r_oclip;
    logic signed [31:0] r_olow;
    logic               w_done;
    logic [31:0]        w_quo;
    logic [31:0]        w_num;
    logic [31:0]        w_bin;
    logic               w_bwe;
    logic [BW-1:0]      w_bwaddr;
    logic [10:0]        w_bwdata;
    logic [BW-1:0]      w_braddr;
    logic [10:0]        w_bin_rdata;

    assign w_num = (r_state == S_SPAN) ? r_span : (i_rdata - r_mn);

    fwh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (w_num),
        .i_den   (r_w),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_bin = (w_quo >= 32'(r_nb)) ? 32'(r_nb) - 32'd1 : w_quo;

    fwh_ram #(.WIDTH(11), .DEPTH(MAX_BUCKETS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_bwe),
        .i_waddr (w_bwaddr),
        .i_wdata (w_bwdata),
        .i_raddr (w_braddr),
        .o_rdata (w_bin_rdata)
    );

    always_comb begin
        w_bwe    = 1'b0;
        w_bwaddr = r_b;
        w_bwdata = '0;
        w_braddr = r_b;
        unique case (r_state)
            S_INIT: w_bwe = 1'b1;
            S_BIN:  w_braddr = w_bin[BW-1:0];
            S_INC: begin
                w_bwe    = 1'b1;
                w_bwaddr = r_bin;
                w_bwdata = w_bin_rdata + 11'd1;
            end
            S_EMIT: begin
                w_bwe    = 1'b1;
                w_braddr = r_b + BW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_b      <= '0;
            r_dstart <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            r_valid  <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_b <= r_b + BW'(1);
                    if (r_b == BW'(MAX_BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_go) begin
                        r_n      <= i_count;
                        r_mn     <= i_min;
                        r_span   <= i_max - i_min;
                        r_w      <= (i_width == '0) ? 31'd1 : i_width;
                        r_idx    <= '0;
                        r_dstart <= 1'b1;
                        r_state  <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    if (w_done) begin
                        if (w_quo >= 32'(MAX_BUCKETS)) begin
                            r_nb   <= 7'(MAX_BUCKETS);
                            r_clip <= 1'b1;
                        end else begin
                            r_nb   <= 7'(w_quo + 32'd1);
                            r_clip <= 1'b0;
                        end
                        r_state <= (r_n == '0) ? S_ELOAD : S_READ;
                        r_b     <= '0;
                        r_low   <= r_mn;
                    end
                end
                S_READ: r_state <= S_DATA;
                S_DATA: begin
                    r_dstart <= 1'b1;
                    r_state  <= S_BIN;
                end
                S_BIN: begin
                    if (w_done) begin
                        r_bin   <= w_bin[BW-1:0];
                        r_state <= S_INC;
                    end
                end
                S_INC: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_n) begin
                        r_state <= S_ELOAD;
                        r_b     <= '0;
                        r_low   <= r_mn;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_ELOAD: r_state <= S_EMIT;
                S_EMIT: begin
                    r_valid  <= 1'b1;
                    r_olow   <= r_low;
                    r_ocount <= w_bin_rdata;
                    r_olast  <= (7'(r_b) == r_nb - 7'd1);
                    r_oclip  <= (7'(r_b) == r_nb - 7'd1) && r_clip;
                    r_low    <= r_low + {1'b0, r_w};
                    r_b      <= r_b + BW'(1);
                    if (7'(r_b) == r_nb - 7'd1) r_state <= S_CLEAR;
                end
                S_CLEAR: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_raddr        = r_idx[AW-1:0];
    assign o_busy         = (r_state != S_IDLE) || i_go;
    assign o_clear        = (r_state == S_CLEAR);
    assign o_valid        = r_valid;
    assign o_bucket_low   = r_olow;
    assign o_bucket_count = r_ocount;
    assign o_clipped      = r_oclip;
    assign o_last_bucket  = r_olast;

endmodule

[rtl/fixed_width_histogram.sv]
// Fixed bin-width histogram of signed Q16.16 samples.
// A sample request is taken at a clock edge where i_start is high and o_busy
// is low, one per cycle while a set is being loaded. The request with
// i_last_item high closes the set and raises o_busy until all results are out.
// The back end first divides the span max minus min by the bucket width to
// get the bucket count, then reads each stored sample from the sample RAM and
// divides its offset by the width in a shared 32-step restoring divider.
// The samples are handled one at a time: each is read, divided and its bin
// counter incremented before the next sample is read.
// Results then come out one per cycle on o_valid, bucket 0 first, with
// o_last_bucket on the final one; the receiver cannot stall them.
// o_busy falls in the cycle after the last result.
// The bucket width is written through i_cfg_valid and o_cfg_ready; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset sets the width to 1.0 and empties the set; o_busy then stays high while
// the bin counter RAM is cleared; each counter is cleared again when emitted.
module fixed_width_histogram #(
    parameter int unsigned MAX_SAMPLES = 1024,
    parameter int unsigned MAX_BUCKETS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [31:0]        i_sample,
    input  logic               i_last_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_bucket_low,
    output logic [10:0]        o_bucket_count,
    output logic               o_clipped,
    output logic               o_last_bucket
);
    import fwh_pkg::*;

    localparam int unsigned CW = $clog2(MAX_SAMPLES+1);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);

    logic [30:0]        r_width;
    t_req               w_req;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_wdata;
    logic [31:0]        w_rdata;
    logic               w_go;
    logic [CW-1:0]      w_count;
    logic signed [31:0] w_min;
    logic signed [31:0] w_max;
    logic               w_clear;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    assign w_req.sample    = i_sample;
    assign w_req.last_item = i_last_item;

    fwh_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_busy  (o_busy),
        .i_req   (w_req),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_go    (w_go),
        .o_count (w_count),
        .o_min   (w_min),
        .o_max   (w_max),
        .i_clear (w_clear)
    );

    fwh_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fwh_back #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_BUCKETS(MAX_BUCKETS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (w_go),
        .i_count        (w_count),
        .i_min          (w_min),
        .i_max          (w_max),
        .i_width        (r_width),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_busy         (o_busy),
        .o_clear        (w_clear),
        .o_valid        (o_valid),
        .o_bucket_low   (o_bucket_low),
        .o_bucket_count (o_bucket_count),
        .o_clipped      (o_clipped),
        .o_last_bucket  (o_last_bucket)
    );

endmodule

[verif/tb_fixed_width_histogram.sv]
`timescale 1ns / 1ps

module tb_fixed_width_histogram;
    import fwh_pkg::*;

    localparam int unsigned MAX_SAMPLES = 1024;
    localparam int unsigned MAX_BUCKETS = 64;
    localparam int unsigned IDLE_LIMIT  = 200000;

    typedef struct {
        logic signed [31:0] bucket_low;
        logic [10:0]        bucket_count;
        logic               clipped;
        logic               last_bucket;
    } t_bucket;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [31:0]        i_sample;
    logic               i_last_item;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [30:0]        i_cfg_data;
    logic               o_valid;
    logic signed [31:0] o_bucket_low;
    logic [10:0]        o_bucket_count;
    logic               o_clipped;
    logic               o_last_bucket;

    fixed_width_histogram uut (.*);

    t_req        pending_samples[$];
    t_bucket     expected_buckets[$];
    logic [31:0] set_samples[$];
    logic signed [31:0] set_min;
    logic signed [31:0] set_max;
    logic [30:0] model_width;
    int          error_count;
    int          idle_cycles;
    int          accepted_samples;
    int          bucket_results;
    int          sets_done;
    bit          steady_phase;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic predict_histogram(input t_req req);
        logic [31:0] w;
        logic [31:0] span;
        logic [32:0] nb;
        logic [31:0] bin;
        logic [10:0] counts[MAX_BUCKETS];
        bit          clip;
        t_bucket     r;
        if (set_samples.size() < MAX_SAMPLES) begin
            set_samples.push_back(req.sample);
            if ($signed(req.sample) < set_min) set_min = req.sample;
            if ($signed(req.sample) > set_max) set_max = req.sample;
        end
        if (!req.last_item) return;
        w = (model_width == 0) ? 32'd1 : {1'b0, model_width};
        span = set_max - set_min;
        nb = {1'b0, span / w} + 33'd1;
        clip = 1'b0;
        if (nb > MAX_BUCKETS) begin
            nb = MAX_BUCKETS;
            clip = 1'b1;
        end
        foreach (counts[k]) counts[k] = '0;
        foreach (set_samples[k]) begin
            bin = (set_samples[k] - set_min) / w;
            if (bin >= nb) bin = nb - 1;
            counts[bin] = counts[bin] + 11'd1;
        end
        for (int k = 0; k < nb; k++) begin
            r.bucket_low   = set_min + w * k;
            r.bucket_count = counts[k];
            r.last_bucket  = (k == nb - 1);
            r.clipped      = r.last_bucket && clip;
            expected_buckets.push_back(r);
        end
        set_samples.delete();
        set_min = MIN_RESET;
        set_max = MAX_RESET;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                predict_histogram({i_sample, i_last_item});
                accepted_samples++;
            end
            if ((i_start && !o_busy) || !i_start) begin
                if (pending_samples.size() > 0
                        && (steady_phase || $urandom_range(99) >= 13)) begin
                    t_req req;
                    req = pending_samples.pop_front();
                    i_start     <= 1'b1;
                    i_sample    <= req.sample;
                    i_last_item <= req.last_item;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            bucket_results++;
            if (expected_buckets.size() == 0) begin
                report_mismatch("unexpected bucket", o_bucket_low, 0);
            end else begin
                t_bucket e;
                e = expected_buckets.pop_front();
                if (o_bucket_low !== e.bucket_low)
                    report_mismatch("bucket_low", o_bucket_low, e.bucket_low);
                if (o_bucket_count !== e.bucket_count)
                    report_mismatch("bucket_count", o_bucket_count, e.bucket_count);
                if (o_clipped !== e.clipped)
                    report_mismatch("clipped", o_clipped, e.clipped);
                if (o_last_bucket !== e.last_bucket)
                    report_mismatch("last_bucket", o_last_bucket, e.last_bucket);
                if (e.last_bucket) sets_done++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d buckets outstanding.", expected_buckets.size());
            $display("fixed_width_histogram: mismatch");
            $finish;
        end
    end

    task automatic write_width(input logic [30:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_width = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_set(input logic [31:0] values[$]);
        foreach (values[k])
            pending_samples.push_back('{values[k], k == values.size() - 1});
    endtask

    task automatic drain;
        wait (pending_samples.size() == 0 && !i_start);
        wait (expected_buckets.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_set(input int n, input int mode);
        logic [31:0] values[$];
        logic [31:0] base;
        base = $urandom;
        for (int k = 0; k < n; k++) begin
            if (mode == 0) values.push_back(base + $urandom_range(model_width * 40));
            else values.push_back($urandom);
        end
        queue_set(values);
    endtask

    initial begin
        logic [31:0] v[$];
        error_count = 0;
        idle_cycles = 0;
        accepted_samples = 0;
        bucket_results = 0;
        sets_done = 0;
        steady_phase = 0;
        model_width = WIDTH_RESET;
        set_min = MIN_RESET;
        set_max = MAX_RESET;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_sample = '0;
        i_last_item = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        v = '{32'h0001_0000};
        queue_set(v);
        v = '{32'h0000_0000, 32'h0001_8000, 32'h0003_0000, 32'hFFFF_0000};
        queue_set(v);
        v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
        queue_set(v);
        drain();
        write_width(31'd1);
        v = '{32'h8000_0000, 32'h7FFF_FFFF};
        queue_set(v);
        v = '{32'd5, 32'd5, 32'd6, 32'd68, 32'd100};
        queue_set(v);
        drain();
        write_width(31'h7FFF_FFFF);
        v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA};
        queue_set(v);
        drain();
        write_width(31'd0);
        v = '{32'd10, 32'd12, 32'd11};
        queue_set(v);
        drain();

        write_width(31'h0000_4000);
        for (int s = 0; s < 8; s++) random_set($urandom_range(1, 8), s % 4 == 3);
        drain();
        write_width(31'(1 + $urandom_range(31'h7FFF_FFFE)));
        for (int s = 0; s < 6; s++) random_set($urandom_range(1, 6), s % 2);
        drain();
        write_width(31'h0001_0000);
        steady_phase = 1;
        for (int s = 0; s < 8; s++) random_set($urandom_range(1, 6), s % 4 == 3);
        drain();
        steady_phase = 0;

        $display("Covered %0d sample requests in %0d sets, %0d bucket results checked.",
                 accepted_samples, sets_done, bucket_results);
        if (error_count == 0) begin
            $display("fixed_width_histogram: match");
        end else begin
            $display("fixed_width_histogram: mismatch");
        end
        $finish;
    end
endmodule
